// ===== rtl/core/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and hash table for the stuffed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 6;
  localparam int BCNT_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int BUFFER_BYTES_DEF  = 128;
  localparam int PAYLOAD_DEPTH_DEF = 64;
  localparam int JOBQ_DEPTH        = 2;
  localparam int OFIFO_DEPTH       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

  localparam logic [BYTE_W-1:0] RST_START_FLAG  = 8'hFF;
  localparam logic [BYTE_W-1:0] RST_END_FLAG    = 8'hFE;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'hFD;
  localparam logic [CNT_W-1:0]  RST_MAX_PAYLOAD = 6'd50;
  localparam logic [CNT_W-1:0]  PAYLOAD_CAP     = 6'd50;

  // stored bytes besides the payload: start, command, length, hash
  localparam logic [BCNT_W-1:0] FRAME_OVERHEAD = 8'd4;
  localparam logic [BCNT_W-1:0] HDR_BYTES      = 8'd3;
  localparam logic [BYTE_W-1:0] ESC_OFFSET     = 8'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_flag;
    logic [BYTE_W-1:0] end_flag;
    logic [BYTE_W-1:0] escape_code;
    logic [CNT_W-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] command;
    logic [CNT_W-1:0]  count;
    logic              bank;
    logic              has_data;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] command;
    logic [CNT_W-1:0]  data_count;
    logic [CNT_W-1:0]  data_index;
    logic [BYTE_W-1:0] data_value;
    logic              last;
  } res_t;

  localparam logic [BYTE_W-1:0] PERM_ROM [256] = '{
    8'h00,8'h77,8'hee,8'h99,8'h07,8'h70,8'he9,8'h9e,8'h0e,8'h79,8'he0,8'h97,
    8'h09,8'h7e,8'he7,8'h90,8'h1d,8'h6a,8'hf3,8'h84,8'h1a,8'h6d,8'hf4,8'h83,
    8'h13,8'h64,8'hfd,8'h8a,8'h14,8'h63,8'hfa,8'h8d,8'h3b,8'h4c,8'hd5,8'ha2,
    8'h3c,8'h4b,8'hd2,8'ha5,8'h35,8'h42,8'hdb,8'hac,8'h32,8'h45,8'hdc,8'hab,
    8'h26,8'h51,8'hc8,8'hbf,8'h21,8'h56,8'hcf,8'hb8,8'h28,8'h5f,8'hc6,8'hb1,
    8'h2f,8'h58,8'hc1,8'hb6,8'h76,8'h01,8'h98,8'hef,8'h71,8'h06,8'h9f,8'he8,
    8'h78,8'h0f,8'h96,8'he1,8'h7f,8'h08,8'h91,8'he6,8'h6b,8'h1c,8'h85,8'hf2,
    8'h6c,8'h1b,8'h82,8'hf5,8'h65,8'h12,8'h8b,8'hfc,8'h62,8'h15,8'h8c,8'hfb,
    8'h4d,8'h3a,8'ha3,8'hd4,8'h4a,8'h3d,8'ha4,8'hd3,8'h43,8'h34,8'had,8'hda,
    8'h44,8'h33,8'haa,8'hdd,8'h50,8'h27,8'hbe,8'hc9,8'h57,8'h20,8'hb9,8'hce,
    8'h5e,8'h29,8'hb0,8'hc7,8'h59,8'h2e,8'hb7,8'hc0,8'hed,8'h9a,8'h03,8'h74,
    8'hea,8'h9d,8'h04,8'h73,8'he3,8'h94,8'h0d,8'h7a,8'he4,8'h93,8'h0a,8'h7d,
    8'hf0,8'h87,8'h1e,8'h69,8'hf7,8'h80,8'h19,8'h6e,8'hfe,8'h89,8'h10,8'h67,
    8'hf9,8'h8e,8'h17,8'h60,8'hd6,8'ha1,8'h38,8'h4f,8'hd1,8'ha6,8'h3f,8'h48,
    8'hd8,8'haf,8'h36,8'h41,8'hdf,8'ha8,8'h31,8'h46,8'hcb,8'hbc,8'h25,8'h52,
    8'hcc,8'hbb,8'h22,8'h55,8'hc5,8'hb2,8'h2b,8'h5c,8'hc2,8'hb5,8'h2c,8'h5b,
    8'h9b,8'hec,8'h75,8'h02,8'h9c,8'heb,8'h72,8'h05,8'h95,8'he2,8'h7b,8'h0c,
    8'h92,8'he5,8'h7c,8'h0b,8'h86,8'hf1,8'h68,8'h1f,8'h81,8'hf6,8'h6f,8'h18,
    8'h88,8'hff,8'h66,8'h11,8'h8f,8'hf8,8'h61,8'h16,8'ha0,8'hd7,8'h4e,8'h39,
    8'ha7,8'hd0,8'h49,8'h3e,8'hae,8'hd9,8'h40,8'h37,8'ha9,8'hde,8'h47,8'h30,
    8'hbd,8'hca,8'h53,8'h24,8'hba,8'hcd,8'h54,8'h23,8'hb3,8'hc4,8'h5d,8'h2a,
    8'hb4,8'hc3,8'h5a,8'h2d
  };

endpackage

`default_nettype wire

// ===== rtl/core/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Byte intake: flag and escape decode, running hash, frame check, payload
// writes into the ping-pong store and job issue toward the drain side.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front #(
  parameter int BUFFER_BYTES  = sfr_pkg::BUFFER_BYTES_DEF,
  parameter int PAYLOAD_DEPTH = sfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sfr_pkg::cfg_t                      cfg,
  input  logic                               in_push,
  input  logic [sfr_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                               in_full,
  input  logic                               q_full,
  output logic                               q_push,
  output sfr_pkg::job_t                      q_job,
  input  sfr_pkg::rel_t                      rel,
  output logic                               mem_we,
  output logic [$clog2(PAYLOAD_DEPTH):0]     mem_waddr,
  output logic [sfr_pkg::BYTE_W-1:0]         mem_wdata
);
  import sfr_pkg::*;

  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

  logic [BCNT_W-1:0] byte_count_r, byte_count_nxt;
  logic              esc_r, esc_nxt;
  logic              fis_r, fis_nxt;
  logic [BYTE_W-1:0] hash_r, hash_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] dlen_r, dlen_nxt;
  logic              wsel_r, wsel_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic              accept;
  logic              is_start;
  logic              is_end;
  logic              is_mark;
  logic              is_data;
  logic              room;
  logic              store;
  logic [BYTE_W-1:0] sb;
  logic [BCNT_W-1:0] si;
  logic [BYTE_W-1:0] data_b;
  logic [BCNT_W:0]   pidx;
  logic [CNT_W-1:0]  limit;
  logic              ok;

  assign in_full  = q_full | busy_r[wsel_r];
  assign accept   = in_push & ~in_full;
  assign is_start = (in_rx_byte == cfg.start_flag);
  assign is_end   = ~is_start & (in_rx_byte == cfg.end_flag);
  assign is_mark  = ~is_start & ~is_end & ~esc_r & (in_rx_byte == cfg.escape_code);
  assign is_data  = ~is_start & ~is_end & ~is_mark;
  assign room     = (byte_count_r < BCNT_W'(BUFFER_BYTES));
  assign data_b   = esc_r ? in_rx_byte + ESC_OFFSET : in_rx_byte;
  assign store    = accept & (is_start | (is_data & room));
  assign sb       = is_start ? in_rx_byte : data_b;
  assign si       = is_start ? '0 : byte_count_r;
  assign pidx     = {1'b0, si} - {1'b0, HDR_BYTES};

  assign limit = (cfg.max_payload > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg.max_payload;
  assign ok    = (byte_count_r >= FRAME_OVERHEAD) & fis_r & held_valid_r &
                 (hash_r == held_r) & (dlen_r == byte_count_r - FRAME_OVERHEAD) &
                 (dlen_r <= {2'b00, limit});

  assign q_push          = accept & is_end;
  assign q_job.status    = ~ok;
  assign q_job.command   = ok ? cmd_r : '0;
  assign q_job.count     = ok ? dlen_r[CNT_W-1:0] : '0;
  assign q_job.bank      = wsel_r;
  assign q_job.has_data  = ok & (dlen_r != '0);

  assign mem_we    = store & (si >= HDR_BYTES) & (pidx < (BCNT_W+1)'(PAYLOAD_DEPTH));
  assign mem_waddr = {wsel_r, pidx[IDX_W-1:0]};
  assign mem_wdata = sb;

  always_comb begin
    byte_count_nxt = byte_count_r;
    esc_nxt        = esc_r;
    fis_nxt        = fis_r;
    hash_nxt       = hash_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    cmd_nxt        = cmd_r;
    dlen_nxt       = dlen_r;
    wsel_nxt       = wsel_r;
    busy_nxt       = busy_r;

    if (accept & ~is_start & ~is_end) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (is_mark) begin
        esc_nxt = 1'b1;
      end
    end

    if (store) begin
      if (si == '0) begin
        fis_nxt        = (sb == cfg.start_flag);
        hash_nxt       = '0;
        held_valid_nxt = 1'b0;
      end else begin
        if (held_valid_r) begin
          hash_nxt = PERM_ROM[hash_r ^ held_r];
        end
        held_nxt       = sb;
        held_valid_nxt = 1'b1;
      end
      if (si == BCNT_W'(1)) begin
        cmd_nxt = sb;
      end
      if (si == BCNT_W'(2)) begin
        dlen_nxt = sb;
      end
      byte_count_nxt = si + BCNT_W'(1);
    end else if (accept & is_data) begin
      // buffer full, frame restarts empty
      byte_count_nxt = '0;
    end

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push) begin
      byte_count_nxt = '0;
      if (q_job.has_data) begin
        busy_nxt[wsel_r] = 1'b1;
        wsel_nxt         = ~wsel_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      esc_r        <= 1'b0;
      fis_r        <= 1'b0;
      hash_r       <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      cmd_r        <= '0;
      dlen_r       <= '0;
      wsel_r       <= 1'b0;
      busy_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      esc_r        <= esc_nxt;
      fis_r        <= fis_nxt;
      hash_r       <= hash_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      cmd_r        <= cmd_nxt;
      dlen_r       <= dlen_nxt;
      wsel_r       <= wsel_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_jobq.sv =====
// ----------------------------------------------------------------------------
// sfr_jobq
// Short job queue between the byte intake and the payload drain.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  sfr_pkg::job_t q_job_in,
  output logic          q_full,
  input  logic          q_pop,
  output sfr_pkg::job_t q_job_out,
  output logic          q_empty
);
  import sfr_pkg::*;

  localparam int PTR_W = $clog2(JOBQ_DEPTH);

  job_t             ent_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full    = (cnt_r == (PTR_W+1)'(JOBQ_DEPTH));
  assign q_empty   = (cnt_r == '0);
  assign q_job_out = ent_r[rp_r];
  assign do_push   = q_push & ~q_full;
  assign do_pop    = q_pop & ~q_empty;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == PTR_W'(JOBQ_DEPTH-1)) ? '0 : wp_r + PTR_W'(1)) : wp_r;
    rp_nxt  = do_pop ? ((rp_r == PTR_W'(JOBQ_DEPTH-1)) ? '0 : rp_r + PTR_W'(1)) : rp_r;
    cnt_nxt = cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= q_job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Payload drain: ping-pong payload store, read sequencer and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back #(
  parameter int PAYLOAD_DEPTH = sfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  sfr_pkg::job_t                  q_job,
  output logic                           q_pop,
  input  logic                           mem_we,
  input  logic [$clog2(PAYLOAD_DEPTH):0] mem_waddr,
  input  logic [sfr_pkg::BYTE_W-1:0]     mem_wdata,
  output sfr_pkg::rel_t                  rel,
  output sfr_pkg::res_t                  head,
  output logic                           out_empty,
  input  logic                           out_pop
);
  import sfr_pkg::*;

  localparam int IDX_W  = $clog2(PAYLOAD_DEPTH);
  localparam int OPTR_W = $clog2(OFIFO_DEPTH);

  logic [BYTE_W-1:0] mem_r [2**(IDX_W+1)];
  logic [BYTE_W-1:0] rdata_r;

  logic              act_r, act_nxt;
  job_t              job_r, job_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  res_t              s1_res_r, s1_res_nxt;
  logic              s1_mem_r, s1_mem_nxt;

  res_t              of_r [OFIFO_DEPTH];
  logic [OPTR_W-1:0] of_wp_r, of_wp_nxt;
  logic [OPTR_W-1:0] of_rp_r, of_rp_nxt;
  logic [OPTR_W:0]   of_cnt_r, of_cnt_nxt;

  logic              credit;
  logic              issue;
  logic              last_item;
  logic              rd_en;
  logic [IDX_W:0]    raddr;
  res_t              meta;
  res_t              push_res;
  logic              of_pop;

  assign q_pop     = ~act_r & ~q_empty;
  assign credit    = ({1'b0, of_cnt_r} + (OPTR_W+2)'(s1_valid_r)) < (OPTR_W+2)'(OFIFO_DEPTH);
  assign issue     = act_r & credit;
  assign last_item = ~job_r.has_data | (idx_r == job_r.count - CNT_W'(1));
  assign rd_en     = issue & job_r.has_data;
  assign raddr     = {job_r.bank, IDX_W'(idx_r)};

  assign rel.valid = rd_en & last_item;
  assign rel.bank  = job_r.bank;

  always_comb begin
    meta.status     = job_r.status;
    meta.command    = job_r.command;
    meta.data_count = job_r.count;
    meta.data_index = job_r.has_data ? idx_r : '0;
    meta.data_value = '0;
    meta.last       = last_item;
  end

  always_comb begin
    push_res            = s1_res_r;
    push_res.data_value = s1_mem_r ? rdata_r : '0;
  end

  always_comb begin
    act_nxt      = act_r;
    job_nxt      = job_r;
    idx_nxt      = idx_r;
    s1_valid_nxt = 1'b0;
    s1_res_nxt   = s1_res_r;
    s1_mem_nxt   = s1_mem_r;
    if (q_pop) begin
      act_nxt = 1'b1;
      job_nxt = q_job;
      idx_nxt = '0;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
      s1_res_nxt   = meta;
      s1_mem_nxt   = job_r.has_data;
      if (last_item) begin
        act_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  // payload store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // result queue
  assign out_empty = (of_cnt_r == '0);
  assign head      = of_r[of_rp_r];
  assign of_pop    = out_pop & ~out_empty;

  always_comb begin
    of_wp_nxt  = s1_valid_r ?
                 ((of_wp_r == OPTR_W'(OFIFO_DEPTH-1)) ? '0 : of_wp_r + OPTR_W'(1)) : of_wp_r;
    of_rp_nxt  = of_pop ?
                 ((of_rp_r == OPTR_W'(OFIFO_DEPTH-1)) ? '0 : of_rp_r + OPTR_W'(1)) : of_rp_r;
    of_cnt_nxt = of_cnt_r + (OPTR_W+1)'(s1_valid_r) - (OPTR_W+1)'(of_pop);
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      of_r[of_wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      job_r      <= '0;
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_res_r   <= '0;
      s1_mem_r   <= 1'b0;
      of_wp_r    <= '0;
      of_rp_r    <= '0;
      of_cnt_r   <= '0;
    end else begin
      act_r      <= act_nxt;
      job_r      <= job_nxt;
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_res_r   <= s1_res_nxt;
      s1_mem_r   <= s1_mem_nxt;
      of_wp_r    <= of_wp_nxt;
      of_rp_r    <= of_rp_nxt;
      of_cnt_r   <= of_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stuffed_frame_receiver_pearson_unit.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_pearson_unit
// Byte-stuffed frame receiver with Pearson hash check and payload drain.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+--------------------------
//   in_     | in        | push / full                  | rx_byte
//   out_    | out       | pop / empty                  | status command data_count
//           |           |                              | data_index data_value last
//   cfg_    | in        | valid / ready (always ready) | index wdata
//
// One byte per cycle at intake while full is low; the hash step is one table
// lookup. A frame's results drain through the registered read stage into the
// result queue, and a new read issues while earlier results are still in
// flight (result queue credit counts the read stage). Intake stalls (full
// high) while both store banks hold undrained frames or the job queue is
// full. Reset clears control state; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stuffed_frame_receiver_pearson_unit #(
  parameter int BUFFER_BYTES  = sfr_pkg::BUFFER_BYTES_DEF,
  parameter int PAYLOAD_DEPTH = sfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_status,
  output logic [sfr_pkg::BYTE_W-1:0]    out_command,
  output logic [sfr_pkg::CNT_W-1:0]     out_data_count,
  output logic [sfr_pkg::CNT_W-1:0]     out_data_index,
  output logic [sfr_pkg::BYTE_W-1:0]    out_data_value,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]    cfg_wdata
);
  import sfr_pkg::*;

  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

  cfg_t              cfg_r, cfg_nxt;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  job_t              q_job_in;
  job_t              q_job_out;
  rel_t              rel;
  res_t              head;
  logic              mem_we;
  logic [IDX_W:0]    mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        CFG_START_FLAG:  cfg_nxt.start_flag  = cfg_wdata;
        CFG_END_FLAG:    cfg_nxt.end_flag    = cfg_wdata;
        CFG_ESCAPE_CODE: cfg_nxt.escape_code = cfg_wdata;
        CFG_MAX_PAYLOAD: cfg_nxt.max_payload = cfg_wdata[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_flag  <= RST_START_FLAG;
      cfg_r.end_flag    <= RST_END_FLAG;
      cfg_r.escape_code <= RST_ESCAPE_CODE;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfr_front #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job_in),
    .rel        (rel),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  sfr_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_job_in  (q_job_in),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_job_out (q_job_out),
    .q_empty   (q_empty)
  );

  sfr_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job_out),
    .q_pop     (q_pop),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rel       (rel),
    .head      (head),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_status     = head.status;
  assign out_command    = head.command;
  assign out_data_count = head.data_count;
  assign out_data_index = head.data_index;
  assign out_data_value = head.data_value;
  assign out_last       = head.last;

  a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |->
      (out_last && out_command == '0 && out_data_count == '0 && out_data_value == '0))
    else $error("reject result carries data");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_status && out_data_count != '0) |->
      (out_data_index < out_data_count &&
       out_last == (out_data_index == out_data_count - CNT_W'(1))))
    else $error("payload index or last flag out of order");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("intake stalled after reset");

endmodule

`default_nettype wire

// ===== sim/stuffed_frame_receiver_pearson_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_pearson_unit_tb
// Self-checking bench for the byte-stuffed frame receiver. Serial bytes are
// pushed with random gaps while results are popped with random stalls. A
// bit-accurate deframer runs alongside the bytes and queues the results each
// end flag should produce; every popped result is compared field by field.
// Covers good and damaged frames, escaping, flag and limit registers at
// their extremes, a frame held open across a register write, and overflow.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_pearson_unit_tb;
  import sfr_pkg::*;

  typedef logic [BYTE_W-1:0] octet_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_HASH,
    FRAME_BAD_LENGTH,
    FRAME_NO_START,
    FRAME_TRUNCATED
  } frame_flaw_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  octet_t               in_rx_byte = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_status;
  octet_t               out_command;
  logic [CNT_W-1:0]     out_data_count;
  logic [CNT_W-1:0]     out_data_index;
  octet_t               out_data_value;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START_FLAG;
  octet_t               cfg_wdata = '0;

  // deframer state, mirrors the block
  octet_t           reg_start = RST_START_FLAG;
  octet_t           reg_end = RST_END_FLAG;
  octet_t           reg_esc = RST_ESCAPE_CODE;
  logic [CNT_W-1:0] reg_max = RST_MAX_PAYLOAD;
  int               stored_cnt = 0;
  bit               esc_pending = 1'b0;
  bit               first_is_start = 1'b0;
  octet_t           run_hash = '0;
  octet_t           held_byte = '0;
  bit               held_valid = 1'b0;
  octet_t           cmd_byte = '0;
  octet_t           decl_len = '0;
  octet_t           payload_mem [PAYLOAD_DEPTH_DEF];

  res_t   expected_results[$];
  bit     no_gaps = 1'b0;
  int     pop_hold = 0;
  int     err_count = 0;
  int     n_bytes = 0;
  int     n_results = 0;
  int     n_rejects = 0;
  int     n_settings = 1;
  longint cycle_count = 0;

  stuffed_frame_receiver_pearson_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_command    (out_command),
    .out_data_count (out_data_count),
    .out_data_index (out_data_index),
    .out_data_value (out_data_value),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic octet_t frame_hash(input octet_t body[$]);
    octet_t h;
    h = '0;
    foreach (body[i]) h = PERM_ROM[h ^ body[i]];
    return h;
  endfunction

  // ---------------- deframer ----------------

  function void store_frame_byte(input octet_t b);
    if (stored_cnt == 0) begin
      first_is_start = (b == reg_start);
      run_hash = '0;
      held_valid = 1'b0;
    end else begin
      if (held_valid) run_hash = PERM_ROM[run_hash ^ held_byte];
      held_byte = b;
      held_valid = 1'b1;
    end
    if (stored_cnt == 1) cmd_byte = b;
    if (stored_cnt == 2) decl_len = b;
    if (stored_cnt >= 3 && stored_cnt - 3 < PAYLOAD_DEPTH_DEF) payload_mem[stored_cnt - 3] = b;
    stored_cnt++;
  endfunction

  function void close_frame();
    int   flen;
    int   lim;
    bit   ok;
    res_t r;
    flen = stored_cnt + 1;
    lim = (reg_max > PAYLOAD_CAP) ? int'(PAYLOAD_CAP) : int'(reg_max);
    ok = flen >= 5 && first_is_start && held_valid && run_hash == held_byte &&
         int'(decl_len) == flen - 5 && int'(decl_len) <= lim;
    stored_cnt = 0;
    r = '0;
    r.last = 1'b1;
    if (!ok) begin
      r.status = 1'b1;
      expected_results.push_back(r);
    end else if (decl_len == 0) begin
      r.command = cmd_byte;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < int'(decl_len); i++) begin
        r.command = cmd_byte;
        r.data_count = decl_len[CNT_W-1:0];
        r.data_index = i[CNT_W-1:0];
        r.data_value = payload_mem[i];
        r.last = (i + 1 == int'(decl_len));
        expected_results.push_back(r);
      end
    end
  endfunction

  function void deframe_byte(input octet_t b);
    octet_t v;
    v = b;
    if (v == reg_start) begin
      stored_cnt = 0;
      store_frame_byte(v);
    end else if (v == reg_end) begin
      close_frame();
    end else if (!esc_pending && v == reg_esc) begin
      esc_pending = 1'b1;
    end else begin
      if (esc_pending) begin
        v = v + ESC_OFFSET;
        esc_pending = 1'b0;
      end
      if (stored_cnt >= BUFFER_BYTES_DEF) stored_cnt = 0;
      else store_frame_byte(v);
    end
  endfunction

  // ---------------- result side ----------------

  function void check_result();
    res_t e;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: status %0d command %0h value %0h",
             out_status, out_command, out_data_value);
      err_count++;
      return;
    end
    e = expected_results.pop_front();
    n_results++;
    if (out_status) n_rejects++;
    if (out_status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_status);
      err_count++;
    end
    if (out_command !== e.command) begin
      $error("command: expected %0h, got %0h", e.command, out_command);
      err_count++;
    end
    if (out_data_count !== e.data_count) begin
      $error("data_count: expected %0d, got %0d", e.data_count, out_data_count);
      err_count++;
    end
    if (out_data_index !== e.data_index) begin
      $error("data_index: expected %0d, got %0d", e.data_index, out_data_index);
      err_count++;
    end
    if (out_data_value !== e.data_value) begin
      $error("data_value: expected %0h, got %0h", e.data_value, out_data_value);
      err_count++;
    end
    if (out_last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, out_last);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) check_result();
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        pop_hold = pick_gap();
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_byte(input octet_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    deframe_byte(b);
    n_bytes++;
  endtask

  // escape flag-like bytes, and now and then an ordinary one, unless the lowered byte is a start or end flag
  task automatic send_stuffed(input octet_t b);
    octet_t s;
    s = b - ESC_OFFSET;
    if ((b == reg_start || b == reg_end || b == reg_esc || $urandom_range(0, 15) == 0) &&
        s != reg_start && s != reg_end) begin
      send_byte(reg_esc);
      send_byte(s);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic send_body(input octet_t cmd, input octet_t payload[$],
                           input frame_flaw_t flaw);
    octet_t body[$];
    octet_t h;
    octet_t len;
    len = 8'(payload.size());
    if (flaw == FRAME_BAD_LENGTH) len = len + 8'($urandom_range(1, 3));
    body.push_back(cmd);
    body.push_back(len);
    foreach (payload[i]) body.push_back(payload[i]);
    h = frame_hash(body);
    if (flaw == FRAME_BAD_HASH) h = h ^ 8'($urandom_range(1, 255));
    if (flaw == FRAME_TRUNCATED) begin
      send_stuffed(cmd);
    end else begin
      foreach (body[i]) send_stuffed(body[i]);
      send_stuffed(h);
    end
    send_byte(reg_end);
  endtask

  task automatic send_frame(input octet_t cmd, input octet_t payload[$],
                            input frame_flaw_t flaw);
    if (flaw != FRAME_NO_START) send_byte(reg_start);
    send_body(cmd, payload, flaw);
  endtask

  function automatic octet_t pick_data();
    case ($urandom_range(0, 9))
      0: return reg_start;
      1: return reg_end;
      2: return reg_esc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic settle_block();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input octet_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_FLAG:  reg_start = val;
      CFG_END_FLAG:    reg_end = val;
      CFG_ESCAPE_CODE: reg_esc = val;
      CFG_MAX_PAYLOAD: reg_max = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input octet_t sflag, input octet_t eflag,
                              input octet_t esc, input logic [CNT_W-1:0] maxp);
    write_reg(CFG_START_FLAG, sflag);
    write_reg(CFG_END_FLAG, eflag);
    write_reg(CFG_ESCAPE_CODE, esc);
    write_reg(CFG_MAX_PAYLOAD, {2'b00, maxp});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_flags(output octet_t sflag, output octet_t eflag, output octet_t esc);
    sflag = 8'($urandom_range(0, 255));
    do eflag = 8'($urandom_range(0, 255)); while (eflag == sflag);
    do esc = 8'($urandom_range(0, 255)); while (esc == sflag || esc == eflag);
  endtask

  task automatic make_payload(input int n, output octet_t payload[$]);
    payload = {};
    repeat (n) payload.push_back(pick_data());
  endtask

  task automatic send_random_frame();
    octet_t pl[$];
    int     lim;
    int     n;
    int     r;
    lim = (reg_max > PAYLOAD_CAP) ? int'(PAYLOAD_CAP) : int'(reg_max);
    r = $urandom_range(0, 99);
    if (r < 85) n = $urandom_range(0, 6);
    else if (r < 95) n = $urandom_range(7, 20);
    else n = $urandom_range(0, lim + 1);
    make_payload(n, pl);
    r = $urandom_range(0, 99);
    if (r < 68) send_frame(pick_data(), pl, FRAME_GOOD);
    else if (r < 78) send_frame(pick_data(), pl, FRAME_BAD_HASH);
    else if (r < 84) send_frame(pick_data(), pl, FRAME_BAD_LENGTH);
    else if (r < 89) send_frame(pick_data(), pl, FRAME_NO_START);
    else if (r < 93) send_frame(pick_data(), pl, FRAME_TRUNCATED);
    else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------- tests ----------------

  task automatic test_basic_frames();
    octet_t pl[$];
    octet_t body[$];
    octet_t h;
    // empty payload, then a lone end flag
    pl = {};
    send_frame(8'h00, pl, FRAME_GOOD);
    send_byte(reg_end);
    // escape left pending across the start flag applies to the command byte
    send_byte(reg_esc);
    send_byte(reg_start);
    send_byte(8'h10);
    body = '{8'h12, 8'h01, 8'hFF};
    h = frame_hash(body);
    send_stuffed(8'h01);
    send_stuffed(8'hFF);
    send_stuffed(h);
    send_byte(reg_end);
    // escaped bytes landing on flag values, byte extremes
    pl = '{8'h00, 8'hFE, 8'hFD, 8'h7F};
    send_frame(8'hFF, pl, FRAME_GOOD);
  endtask

  task automatic test_register_extremes();
    octet_t pl[$];
    settle_block();
    write_config(8'h00, 8'hFF, 8'h80, 6'd0);
    pl = {};
    send_frame(8'h80, pl, FRAME_GOOD);
    pl = '{8'h00};
    send_frame(8'h01, pl, FRAME_GOOD);
    settle_block();
    // limit above the cap acts as the cap
    write_config(8'h5A, 8'hA5, 8'h01, 6'd63);
    make_payload(50, pl);
    send_frame(8'h3C, pl, FRAME_GOOD);
    make_payload(51, pl);
    send_frame(8'h3D, pl, FRAME_GOOD);
    // start byte stored under one flag value, frame finished under another
    send_byte(reg_start);
    settle_block();
    write_config(8'h33, 8'h44, 8'h55, 6'd7);
    make_payload(7, pl);
    send_body(8'h44, pl, FRAME_GOOD);
    make_payload(8, pl);
    send_frame(8'h33, pl, FRAME_GOOD);
  endtask

  task automatic test_buffer_overflow();
    octet_t pl[$];
    settle_block();
    write_config(RST_START_FLAG, RST_END_FLAG, RST_ESCAPE_CODE, RST_MAX_PAYLOAD);
    send_byte(reg_start);
    repeat (130) send_byte(8'($urandom_range(0, 250)));
    send_byte(reg_end);
    make_payload(3, pl);
    send_frame(8'h21, pl, FRAME_GOOD);
  endtask

  task automatic test_random_traffic();
    octet_t sflag;
    octet_t eflag;
    octet_t esc;
    int     sent0;
    bit     paused;
    paused = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      settle_block();
      pick_flags(sflag, eflag, esc);
      case (phase)
        0: write_config(RST_START_FLAG, RST_END_FLAG, RST_ESCAPE_CODE, RST_MAX_PAYLOAD);
        3: write_config(sflag, eflag, esc, PAYLOAD_CAP);
        default: write_config(sflag, eflag, esc, 6'($urandom_range(0, 63)));
      endcase
      no_gaps = (phase == 2);
      sent0 = n_bytes;
      while (n_bytes - sent0 < 15) begin
        if (phase == 1 && !paused && n_bytes - sent0 > 6) begin
          settle_block();
          paused = 1'b1;
        end
        send_random_frame();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_frames();
    test_register_extremes();
    test_buffer_overflow();
    test_random_traffic();
    settle_block();
    $display("%0d serial bytes over %0d register settings, %0d results checked",
             n_bytes, n_settings, n_results);
    $display("%0d frames rejected, %0d mismatches", n_rejects, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_front.sv
rtl/core/sfr_jobq.sv
rtl/core/sfr_back.sv
rtl/core/stuffed_frame_receiver_pearson_unit.sv
sim/stuffed_frame_receiver_pearson_unit_tb.sv
